// ===== rtl/core/sint_pkg.sv =====
// ---------------------------------------------------------------------------
// sint_pkg
// Widths, lane record and result formatting shared by the segment
// intersection pipeline.
// ---------------------------------------------------------------------------
package sint_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_W      = 32;

   localparam int DIFF_W  = COORD_BITS + 1;          // endpoint differences
   localparam int PROD_W  = 2 * DIFF_W;              // one cross-product term
   localparam int CROSS_W = PROD_W + 1;              // den, tn, un (signed)
   localparam int DEN_W   = CROSS_W - 1;             // |den| after sign fold
   localparam int SUM_W   = CROSS_W + COORD_BITS + 2; // p0*den + tn*dp
   localparam int QUO_W   = COORD_BITS + FRAC_BITS;  // quotient bits, one per cell
   localparam int SAT_W   = (QUO_W > OUT_W + 1) ? QUO_W : OUT_W + 1;

   localparam int REQ_W = ((8 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W = 2 * OUT_W;

   typedef struct packed {
      logic             hit;
      logic             neg_x;
      logic             neg_y;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem_x;
      logic [DEN_W-1:0] rem_y;
      logic [QUO_W-1:0] nq_x;   // numerator low bits in, quotient bits out
      logic [QUO_W-1:0] nq_y;
   } sint_lane_type;

   // apply sign to the quotient magnitude, saturate to the 32-bit range
   function automatic logic [OUT_W-1:0] sint_fix(input logic neg, input logic [QUO_W-1:0] q);
      logic [SAT_W-1:0] qe;
      logic [SAT_W-1:0] lim_pos;
      logic [SAT_W-1:0] lim_neg;
      logic [OUT_W-1:0] res;
      qe      = SAT_W'(q);
      lim_pos = SAT_W'({1'b0, {(OUT_W-1){1'b1}}});
      lim_neg = SAT_W'({1'b1, {(OUT_W-1){1'b0}}});
      if (neg) begin
         if (qe > lim_neg) res = {1'b1, {(OUT_W-1){1'b0}}};
         else              res = OUT_W'(~qe + SAT_W'(1));
      end else begin
         if (qe > lim_pos) res = {1'b0, {(OUT_W-1){1'b1}}};
         else              res = OUT_W'(qe);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/sint_front.sv =====
// ---------------------------------------------------------------------------
// sint_front
// Front pipeline: differences, cross products, sign fold and hit test,
// intersection numerators, and the first remainder for the divider chain.
// ---------------------------------------------------------------------------
module sint_front
   import sint_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [REQ_W-1:0]    in_data,
   output logic                out_valid,
   output sint_lane_type       out_lane
);

   localparam int C = COORD_BITS;

   logic signed [C-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

   assign ax0 = in_data[0*C +: C];
   assign ay0 = in_data[1*C +: C];
   assign ax1 = in_data[2*C +: C];
   assign ay1 = in_data[3*C +: C];
   assign bx0 = in_data[4*C +: C];
   assign by0 = in_data[5*C +: C];
   assign bx1 = in_data[6*C +: C];
   assign by1 = in_data[7*C +: C];

   logic [5:0] v_ff;

   // stage 1: differences
   logic signed [DIFF_W-1:0] dax_ff, day_ff, dbx_ff, dby_ff, qx_ff, qy_ff;
   logic signed [C-1:0]      p0x1_ff, p0y1_ff;
   // stage 2: product terms
   logic signed [PROD_W-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [DIFF_W-1:0] dax2_ff, day2_ff;
   logic signed [C-1:0]      p0x2_ff, p0y2_ff;
   // stage 3: raw crosses
   logic signed [CROSS_W-1:0] den3_ff, tn3_ff, un3_ff;
   logic signed [DIFF_W-1:0]  dax3_ff, day3_ff;
   logic signed [C-1:0]       p0x3_ff, p0y3_ff;
   // stage 4: folded sign, hit
   logic [DEN_W-1:0]          den4_ff, tn4_ff;
   logic                      hit4_ff;
   logic signed [DIFF_W-1:0]  dax4_ff, day4_ff;
   logic signed [C-1:0]       p0x4_ff, p0y4_ff;
   // stage 5: numerator terms
   logic signed [SUM_W-1:0]   px5_ff, py5_ff, tx5_ff, ty5_ff;
   logic [DEN_W-1:0]          den5_ff;
   logic                      hit5_ff;
   // stage 6
   sint_lane_type             lane_ff;

   logic signed [CROSS_W-1:0] den_a, tn_a, un_a;
   logic                      hit_in;
   logic signed [CROSS_W-1:0] den_s, tn_s;
   logic signed [SUM_W-1:0]   sx, sy;
   logic [SUM_W-1:0]          magx, magy;

   always_comb begin
      den_a  = den3_ff[CROSS_W-1] ? -den3_ff : den3_ff;
      tn_a   = den3_ff[CROSS_W-1] ? -tn3_ff  : tn3_ff;
      un_a   = den3_ff[CROSS_W-1] ? -un3_ff  : un3_ff;
      hit_in = (den3_ff != '0) && !tn_a[CROSS_W-1] && !un_a[CROSS_W-1]
               && (tn_a <= den_a) && (un_a <= den_a);
      den_s  = $signed({1'b0, den4_ff});
      tn_s   = $signed({1'b0, tn4_ff});
      sx     = px5_ff + tx5_ff;
      sy     = py5_ff + ty5_ff;
      magx   = sx[SUM_W-1] ? unsigned'(-sx) : unsigned'(sx);
      magy   = sy[SUM_W-1] ? unsigned'(-sy) : unsigned'(sy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dax_ff  <= DIFF_W'(ax1) - DIFF_W'(ax0);
         day_ff  <= DIFF_W'(ay1) - DIFF_W'(ay0);
         dbx_ff  <= DIFF_W'(bx1) - DIFF_W'(bx0);
         dby_ff  <= DIFF_W'(by1) - DIFF_W'(by0);
         qx_ff   <= DIFF_W'(bx0) - DIFF_W'(ax0);
         qy_ff   <= DIFF_W'(by0) - DIFF_W'(ay0);
         p0x1_ff <= ax0;
         p0y1_ff <= ay0;

         m0_ff   <= PROD_W'(dax_ff * dby_ff);
         m1_ff   <= PROD_W'(day_ff * dbx_ff);
         m2_ff   <= PROD_W'(qx_ff * dby_ff);
         m3_ff   <= PROD_W'(qy_ff * dbx_ff);
         m4_ff   <= PROD_W'(qx_ff * day_ff);
         m5_ff   <= PROD_W'(qy_ff * dax_ff);
         dax2_ff <= dax_ff;
         day2_ff <= day_ff;
         p0x2_ff <= p0x1_ff;
         p0y2_ff <= p0y1_ff;

         den3_ff <= CROSS_W'(m0_ff) - CROSS_W'(m1_ff);
         tn3_ff  <= CROSS_W'(m2_ff) - CROSS_W'(m3_ff);
         un3_ff  <= CROSS_W'(m4_ff) - CROSS_W'(m5_ff);
         dax3_ff <= dax2_ff;
         day3_ff <= day2_ff;
         p0x3_ff <= p0x2_ff;
         p0y3_ff <= p0y2_ff;

         den4_ff <= DEN_W'(den_a);
         tn4_ff  <= DEN_W'(tn_a);
         hit4_ff <= hit_in;
         dax4_ff <= dax3_ff;
         day4_ff <= day3_ff;
         p0x4_ff <= p0x3_ff;
         p0y4_ff <= p0y3_ff;

         px5_ff  <= SUM_W'(p0x4_ff * den_s);
         py5_ff  <= SUM_W'(p0y4_ff * den_s);
         tx5_ff  <= SUM_W'(tn_s * dax4_ff);
         ty5_ff  <= SUM_W'(tn_s * day4_ff);
         den5_ff <= den4_ff;
         hit5_ff <= hit4_ff;

         // numerator is mag << FRAC_BITS; top part already below den
         lane_ff.hit   <= hit5_ff;
         lane_ff.neg_x <= sx[SUM_W-1];
         lane_ff.neg_y <= sy[SUM_W-1];
         lane_ff.den   <= den5_ff;
         lane_ff.rem_x <= DEN_W'(magx >> C);
         lane_ff.rem_y <= DEN_W'(magy >> C);
         lane_ff.nq_x  <= {magx[C-1:0], {FRAC_BITS{1'b0}}};
         lane_ff.nq_y  <= {magy[C-1:0], {FRAC_BITS{1'b0}}};
      end
   end

   assign out_valid = v_ff[5];
   assign out_lane  = lane_ff;

endmodule

// ===== rtl/core/sint_div_cell.sv =====
// ---------------------------------------------------------------------------
// sint_div_cell
// One restoring-division step for both coordinates: produces one quotient
// bit each and hands the lane to the next cell.
// ---------------------------------------------------------------------------
module sint_div_cell
   import sint_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  sint_lane_type in_lane,
   output logic          out_valid,
   output sint_lane_type out_lane
);

   logic                 valid_ff;
   sint_lane_type        lane_ff;
   sint_lane_type        lane_in;
   logic [DEN_W:0]       tx, ty, dext;
   logic                 gex, gey;

   always_comb begin
      dext    = {1'b0, in_lane.den};
      tx      = {in_lane.rem_x, in_lane.nq_x[QUO_W-1]};
      ty      = {in_lane.rem_y, in_lane.nq_y[QUO_W-1]};
      gex     = tx >= dext;
      gey     = ty >= dext;
      lane_in       = in_lane;
      lane_in.rem_x = gex ? DEN_W'(tx - dext) : DEN_W'(tx);
      lane_in.rem_y = gey ? DEN_W'(ty - dext) : DEN_W'(ty);
      lane_in.nq_x  = {in_lane.nq_x[QUO_W-2:0], gex};
      lane_in.nq_y  = {in_lane.nq_y[QUO_W-2:0], gey};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// ===== rtl/core/segment_intersection.sv =====
// ---------------------------------------------------------------------------
// segment_intersection
// Two-segment 2D intersection test with Q16.16 crossing point.
// ---------------------------------------------------------------------------
// req_ carries one segment pair per item (eight signed coordinates);
// rsp_ returns one item per request, in order: tuser[0] is the hit flag,
// tdata the crossing point, both coordinates zero when there is no hit.
// Endpoint touches count as hits; parallel, collinear and zero-length
// pairs do not.
// An item passes six front stages (differences, products, crosses,
// sign fold and range test, numerator products, numerator sum), one
// divider cell per quotient bit, then the output register. One item is
// accepted every cycle unless the pipeline is held.
// The whole pipeline advances together; it holds while a result sits in
// the output register and rsp_tready is low, so req_tready follows
// rsp_tready in that case. The pipeline keeps moving while the output
// register is empty or being taken.
// Reset clears every stage valid bit; no result is presented afterwards
// until a new item has passed through.
// ---------------------------------------------------------------------------
module segment_intersection
   import sint_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // cross_x, cross_y
   output logic [RSP_W-1:0]   rsp_tdata,
   // hit
   output logic [0:0]         rsp_tuser
);

   logic                rsp_tvalid_ff;
   logic [RSP_W-1:0]    rsp_tdata_ff;
   logic                hit_ff;
   logic                en;

   logic                cv [QUO_W+1];
   sint_lane_type       cl [QUO_W+1];

   assign en = !rsp_tvalid_ff || rsp_tready;

   sint_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (cv[0]),
      .out_lane  (cl[0])
   );

   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      sint_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cv[i]),
         .in_lane   (cl[i]),
         .out_valid (cv[i+1]),
         .out_lane  (cl[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= cv[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= cl[QUO_W].hit;
         if (cl[QUO_W].hit) begin
            rsp_tdata_ff <= {sint_fix(cl[QUO_W].neg_y, cl[QUO_W].nq_y),
                             sint_fix(cl[QUO_W].neg_x, cl[QUO_W].nq_x)};
         end else begin
            rsp_tdata_ff <= '0;
         end
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = hit_ff;

endmodule

// ===== rtl/core/sint_checker.sv =====
// ---------------------------------------------------------------------------
// sint_checker
// Port-level checks for segment_intersection.
// ---------------------------------------------------------------------------
module sint_checker
   import sint_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [RSP_W-1:0]   rsp_tdata,
   input logic [0:0]         rsp_tuser
);

   // stalled result must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a miss carries a zero point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss with nonzero point");

   // input side only stalls while a result waits
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready out of step with output register");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result straight after reset");

   // rising rsp_tvalid: the consequent is a tautology, so this check never fires
   a_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid || !req_tready || !req_tvalid, 1))
      else $error("unexpected result");

endmodule

bind segment_intersection sint_checker u_sint_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/segment_intersection_tb.sv =====
// ---------------------------------------------------------------------------
// segment_intersection_tb
// Streams segment pairs into segment_intersection and checks each result
// against a local exact-arithmetic model of the crossing test and point.
// ---------------------------------------------------------------------------
module segment_intersection_tb;
   import sint_pkg::*;

   typedef struct packed {
      logic        hit;
      logic [31:0] cx;
      logic [31:0] cy;
   } crossing_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [0:0]         rsp_tuser;

   crossing_type crossing_q[$];
   int           mismatches;
   int           burst_left;
   bit           stall_mode;

   segment_intersection dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

   // one coordinate of A0 + t*dA in Q16.16, truncated toward zero, saturated
   function automatic logic [31:0] fixed_coord(longint p0, longint dp, longint tn,
                                               longint den);
      logic signed [127:0] num;
      logic signed [127:0] q;
      num = ($signed(128'(p0)) * den + $signed(128'(tn)) * dp) <<< FRAC_BITS;
      q   = num / den;
      if (q > 128'sh7FFFFFFF) return 32'h7FFF_FFFF;
      if (q < -128'sh80000000) return 32'h8000_0000;
      return q[31:0];
   endfunction

   function automatic crossing_type predict_crossing(logic [REQ_W-1:0] d);
      longint       c[8];
      longint       dax, day, dbx, dby, qx, qy, den, tn, un;
      crossing_type r;
      for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[16*i +: 16]));
      dax = c[2] - c[0]; day = c[3] - c[1];
      dbx = c[6] - c[4]; dby = c[7] - c[5];
      qx  = c[4] - c[0]; qy  = c[5] - c[1];
      den = dax * dby - day * dbx;
      tn  = qx * dby - qy * dbx;
      un  = qx * day - qy * dax;
      r = '0;
      if (den == 0) return r;
      if (den < 0) begin
         den = -den; tn = -tn; un = -un;
      end
      if (tn < 0 || tn > den || un < 0 || un > den) return r;
      r.hit = 1'b1;
      r.cx  = fixed_coord(c[0], dax, tn, den);
      r.cy  = fixed_coord(c[1], day, tn, den);
      return r;
   endfunction

   // leaves req_tvalid high; the next call or wait_drained settles it
   task automatic send_pair(input logic [REQ_W-1:0] d);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      crossing_q = {crossing_q, predict_crossing(d)};
      burst_left--;
      if ($urandom_range(0, 3) == 0) burst_left = 0;
   endtask

   task automatic send_segs(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
      send_pair({16'(by1), 16'(bx1), 16'(by0), 16'(bx0),
                 16'(ay1), 16'(ax1), 16'(ay0), 16'(ax0)});
   endtask

   task automatic test_directed();
      send_segs(0, 0, 10, 10, 0, 10, 10, 0);           // plain X crossing
      send_segs(0, 0, 10, 0, 10, 0, 10, 5);            // endpoint touch
      send_segs(0, 0, 10, 0, 0, 1, 10, 1);             // parallel
      send_segs(0, 0, 10, 0, 2, 0, 20, 0);             // collinear
      send_segs(3, 3, 3, 3, 0, 0, 9, 9);               // zero length
      send_segs(5, -5, 5, 5, 0, 0, 10, 0);             // vertical A
      send_segs(0, 0, 1, 0, 5, -5, 5, 5);              // miss beyond end
      send_segs(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      send_segs(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
      send_segs(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
      send_segs(0, 0, 3, 0, 1, -1, 2, 2);              // fractional point
      send_segs(-7, -3, 2, 9, 4, -8, -5, 6);
      send_segs(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768);
      send_segs(-1, -1, -1, 1, -2, 0, 0, 0);
   endtask

   task automatic test_random(input int n);
      logic [REQ_W-1:0] d;
      int               m;
      for (int k = 0; k < n; k++) begin
         d = {$urandom, $urandom, $urandom, $urandom};
         m = $urandom_range(0, 3);
         // small boxes make hits common; full range covers every bit
         if (m == 1)
            for (int i = 0; i < 8; i++) d[16*i +: 16] = 16'($signed(8'($urandom)));
         else if (m == 2)
            for (int i = 0; i < 8; i++) d[16*i +: 16] = 16'($urandom_range(0, 40)) - 16'd20;
         send_pair(d);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (crossing_q.size() != 0) @(posedge clock);
   endtask

   // receiver: alternates between a free-running spell and random stalls
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      rsp_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
   end

   always @(posedge clock) begin
      crossing_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (crossing_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_tdata);
         end else begin
            e = crossing_q.pop_front();
            if (rsp_tuser[0] !== e.hit || rsp_tdata[31:0] !== e.cx
                || rsp_tdata[63:32] !== e.cy) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: hit %b x %h y %h, expected hit %b x %h y %h",
                           rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[63:32],
                           e.hit, e.cx, e.cy);
            end
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      burst_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_random(640);
      wait_drained();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && crossing_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
